// ===== src/allowed_address_range_checker_defines.svh =====
// Assertion macros used by the checker file aarc_checker.sv.
`ifndef ALLOWED_ADDRESS_RANGE_CHECKER_DEFINES_SVH
`define ALLOWED_ADDRESS_RANGE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AARC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aarc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AARC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aarc assertion failed");

`endif

// ===== src/aarc_pkg.sv =====
// Package: constants, opcodes and cell control type of the address range checker.
package aarc_pkg;

  localparam int          TABLE_ENTRIES_DEF = 64;
  localparam logic [31:0] STACK_TOP_RESET   = 32'hBAAA_AFFC;

  localparam int ADDR_W   = 32;
  localparam int OP_W     = 2;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OP_W-1:0] OP_ADD_RANGE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK     = 2'd2;

  typedef struct packed {
    logic              shift;
    logic [ADDR_W-1:0] addr;
  } cell_ctrl_t;

endpackage

// ===== src/aarc_cell.sv =====
// One table cell: holds one range, shifts on insert, forwards the check token and hit flag.
module aarc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  aarc_pkg::cell_ctrl_t     ctrl,
  input  logic                     entry_valid,
  input  logic [aarc_pkg::ADDR_W-1:0] start_in,
  input  logic [aarc_pkg::ADDR_W-1:0] end_in,
  input  logic                     tok_in,
  input  logic                     hit_in,
  output logic [aarc_pkg::ADDR_W-1:0] start_out,
  output logic [aarc_pkg::ADDR_W-1:0] end_out,
  output logic                     tok_out,
  output logic                     hit_out
);

  logic [aarc_pkg::ADDR_W-1:0] start_r;
  logic [aarc_pkg::ADDR_W-1:0] end_r;
  logic                        tok_r;
  logic                        hit_r;
  logic                        hit_nxt;
  logic                        match;

  assign match   = entry_valid && (start_r < ctrl.addr) && (ctrl.addr <= end_r);
  assign hit_nxt = hit_in || (tok_in && match);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      start_r <= start_in;
      end_r   <= end_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
      hit_r <= hit_nxt;
    end
  end

  assign start_out = start_r;
  assign end_out   = end_r;
  assign tok_out   = tok_r;
  assign hit_out   = hit_r;

endmodule

// ===== src/allowed_address_range_checker.sv =====
// Top level: allowed address range checker built on a row of range cells.
// Each input beat carries one operation: add a range (start/end), add an allocation
// (base/size, end wraps mod 2^32) or check an address. A check passes when
// stack_ptr < addr < stack_top, or when start < addr <= end for a stored range.
// One result beat follows every input beat, and the next input beat is taken only
// after that result has entered the output register. Inserts and the unused opcode
// go straight to the result, while a check first waits for the check token to walk
// the cell row one cell per cycle. A result also waits on out_tready when the output
// register is full. An insert into a full table is dropped and flagged. The user
// must write stack_top through cfg_wr_en / cfg_wr_data only while idle; the block
// itself does not enforce this.
module allowed_address_range_checker #(
  parameter int TABLE_ENTRIES = aarc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [aarc_pkg::ADDR_W-1:0]       cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode, region_start, region_end, region_size, check_addr, stack_ptr, zero pad
  input  logic [aarc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // addr_ok, insert_dropped, zero pad
  output logic [aarc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int AW    = aarc_pkg::ADDR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    stack_top_r;
  logic [AW-1:0]    addr_r;
  logic             tok_head_r, tok_head_nxt;
  logic             hit_head_r, hit_head_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             res_drop_r, res_drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic             out_drop_r, out_drop_nxt;

  logic [aarc_pkg::OP_W-1:0] op;
  logic [AW-1:0]    f_start, f_end, f_size, f_addr, f_sp;
  logic [AW-1:0]    new_end;
  logic             accept, full, is_insert, out_free;
  aarc_pkg::cell_ctrl_t ctrl;

  logic [AW-1:0] start_c [TABLE_ENTRIES+1];
  logic [AW-1:0] end_c   [TABLE_ENTRIES+1];
  logic          tok_c   [TABLE_ENTRIES+1];
  logic          hit_c   [TABLE_ENTRIES+1];

  assign op      = in_tdata[1:0];
  assign f_start = in_tdata[33:2];
  assign f_end   = in_tdata[65:34];
  assign f_size  = in_tdata[97:66];
  assign f_addr  = in_tdata[129:98];
  assign f_sp    = in_tdata[161:130];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(TABLE_ENTRIES));
  assign is_insert = (op == aarc_pkg::OP_ADD_RANGE) || (op == aarc_pkg::OP_ADD_ALLOC);
  assign new_end   = (op == aarc_pkg::OP_ADD_ALLOC) ? (f_start + f_size) : f_end;
  assign out_free  = !out_valid_r || out_tready;

  assign ctrl.shift = accept && is_insert && !full;
  assign ctrl.addr  = addr_r;

  assign start_c[0] = f_start;
  assign end_c[0]   = new_end;
  assign tok_c[0]   = tok_head_r;
  assign hit_c[0]   = hit_head_r;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    aarc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .entry_valid (CNT_W'(i) < count_r),
      .start_in    (start_c[i]),
      .end_in      (end_c[i]),
      .tok_in      (tok_c[i]),
      .hit_in      (hit_c[i]),
      .start_out   (start_c[i+1]),
      .end_out     (end_c[i+1]),
      .tok_out     (tok_c[i+1]),
      .hit_out     (hit_c[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tok_head_nxt  = 1'b0;
    hit_head_nxt  = 1'b0;
    res_ok_nxt    = res_ok_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_drop_nxt  = out_drop_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt   = 1'b0;
          res_drop_nxt = 1'b0;
          if (op == aarc_pkg::OP_CHECK) begin
            tok_head_nxt = 1'b1;
            hit_head_nxt = (f_sp < f_addr) && (f_addr < stack_top_r);
            state_nxt    = ST_SCAN;
          end else begin
            if (is_insert) begin
              res_drop_nxt = full;
              if (!full) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (tok_c[TABLE_ENTRIES]) begin
          res_ok_nxt = hit_c[TABLE_ENTRIES];
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_drop_nxt  = res_drop_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      stack_top_r <= aarc_pkg::STACK_TOP_RESET;
      tok_head_r  <= 1'b0;
      hit_head_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tok_head_r  <= tok_head_nxt;
      hit_head_r  <= hit_head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        stack_top_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= f_addr;
    end
    res_ok_r   <= res_ok_nxt;
    res_drop_r <= res_drop_nxt;
    out_ok_r   <= out_ok_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_drop_r, out_ok_r};

endmodule

// ===== src/aarc_checker.sv =====
// Port-level assertion checker for the address range checker, with its bind.
`include "allowed_address_range_checker_defines.svh"

module aarc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [aarc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `AARC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AARC_ASSERT_NOW(a_one_flag, out_tvalid, !(out_tdata[0] && out_tdata[1]))
  `AARC_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:2] == 6'd0)
  `AARC_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)

endmodule

bind allowed_address_range_checker aarc_checker u_aarc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
